// File: rtl/swms_pkg.sv
`default_nettype none

package swms_pkg;

    // Window length, number of axes in use and warm-up length.
    localparam int WINDOW = 200;
    localparam int AXES   = 3;
    localparam int WARMUP = 400;

    localparam int DATA_W = 32;
    localparam int NAXES  = 3;
    localparam int ROW_W  = NAXES * DATA_W;
    localparam int SUM_W  = 40;
    localparam int ACC_W  = 70;
    localparam int ADDR_W = $clog2(WINDOW);
    localparam int IDX_W  = $clog2(WINDOW + 1);
    localparam int WARM_W = $clog2(WARMUP + 1);
    localparam int AX_W   = 2;

    // Divider by the window length: the dividend is taken one chunk at a time and
    // each quotient digit comes from a multiplication by the rounded-up reciprocal.
    localparam int     DIV_CHUNK_W = 16;
    localparam int     DIV_SH      = 2 * ADDR_W + DIV_CHUNK_W;
    localparam int     DIV_RECIP_W = DIV_SH - ADDR_W + 2;
    localparam longint DIV_RECIP   = ((longint'(1) << DIV_SH) + WINDOW - 1) / WINDOW;

    typedef struct packed {
        logic signed [DATA_W-1:0] rate_x;
        logic signed [DATA_W-1:0] rate_y;
        logic signed [DATA_W-1:0] rate_z;
    } t_in_item;

    typedef struct packed {
        logic                     valid_res;
        logic        [DATA_W-1:0] std_x;
        logic        [DATA_W-1:0] std_y;
        logic        [DATA_W-1:0] std_z;
        logic signed [DATA_W-1:0] mean_x;
        logic signed [DATA_W-1:0] mean_y;
        logic signed [DATA_W-1:0] mean_z;
    } t_out_item;

endpackage

`default_nettype wire

// File: rtl/swms_div.sv
`default_nettype none

// Divider by the window length. The dividend is taken sixteen bits at a time,
// and each quotient digit comes from a reciprocal multiplication; each digit
// is a multiply step and then a remainder step.
module swms_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [swms_pkg::ACC_W-1:0] i_dividend,
    output logic                            o_done,
    output logic [swms_pkg::ACC_W-1:0]      o_quot
);

    localparam int CW    = swms_pkg::DIV_CHUNK_W;
    localparam int RW    = swms_pkg::ADDR_W;
    localparam int NCH   = (swms_pkg::ACC_W + CW - 1) / CW;
    localparam int PW    = NCH * CW;
    localparam int CURW  = RW + CW;
    localparam int MW    = swms_pkg::DIV_RECIP_W;
    localparam int PRW   = CURW + MW;
    localparam int CNT_W = $clog2(NCH + 1);
    localparam logic [MW-1:0] RECIP = MW'(swms_pkg::DIV_RECIP);

    logic [PW-1:0]    r_num;
    logic [PW-1:0]    r_q;
    logic [RW-1:0]    r_rem;
    logic [CURW-1:0]  r_cur;
    logic [PRW-1:0]   r_prod;
    logic [CNT_W-1:0] r_cnt;
    logic             r_phase;
    logic             r_busy;
    logic             r_done;
    logic [CURW-1:0]  cur;
    logic [CW-1:0]    digit;
    logic [CURW-1:0]  rem_w;

    always_comb begin
        cur   = {r_rem, r_num[PW-1 -: CW]};
        digit = r_prod[swms_pkg::DIV_SH +: CW];
        rem_w = r_cur - CURW'(digit) * CURW'(swms_pkg::WINDOW);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_cnt   <= '0;
            r_phase <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_num   <= PW'(i_dividend);
                r_q     <= '0;
                r_rem   <= '0;
                r_cnt   <= '0;
                r_phase <= 1'b0;
                r_busy  <= 1'b1;
            end else if (r_busy && !r_phase) begin
                r_cur   <= cur;
                r_prod  <= PRW'(cur) * PRW'(RECIP);
                r_num   <= {r_num[PW-CW-1:0], {CW{1'b0}}};
                r_phase <= 1'b1;
            end else if (r_busy) begin
                r_q     <= {r_q[PW-CW-1:0], digit};
                r_rem   <= rem_w[RW-1:0];
                r_phase <= 1'b0;
                if (r_cnt == CNT_W'(NCH - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q[swms_pkg::ACC_W-1:0];

endmodule

`default_nettype wire

// File: rtl/swms_sqrt.sv
`default_nettype none

// Floor square root of a 64-bit value, two radicand bits per cycle.
module swms_sqrt (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [63:0]                 i_value,
    output logic                             o_done,
    output logic [swms_pkg::DATA_W-1:0]      o_root
);

    logic [63:0]                  r_x;
    logic [33:0]                  r_rem;
    logic [swms_pkg::DATA_W-1:0]  r_root;
    logic [4:0]                   r_cnt;
    logic                         r_busy;
    logic                         r_done;
    logic [34:0]                  rem2;
    logic [34:0]                  trial;
    logic                         take;

    always_comb begin
        rem2  = {r_rem[32:0], r_x[63:62]};
        trial = {1'b0, r_root, 2'b01};
        take  = rem2 >= trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_x    <= i_value;
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_x <= {r_x[61:0], 2'b00};
                if (take) begin
                    r_rem  <= 34'(rem2 - trial);
                    r_root <= {r_root[swms_pkg::DATA_W-2:0], 1'b1};
                end else begin
                    r_rem  <= rem2[33:0];
                    r_root <= {r_root[swms_pkg::DATA_W-2:0], 1'b0};
                end
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

`default_nettype wire

// File: rtl/sliding_window_mean_and_std_core.sv
`default_nettype none

// Channel  | Direction | Handshake                 | Payload
// input    | in        | i_in_valid / o_in_stall   | i_in_data  (rate_x, rate_y, rate_z)
// result   | out       | o_out_valid / i_out_stall | o_out_data (valid_res, std_*, mean_*)
//
// An item is taken in ST_IDLE; then come the sums, three axis means from the shared divider
// and the window write, which is all that is done per item before warm-up.
// After it, each axis adds its squared deviations at one slot a cycle, then divides
// and takes the square root.
// After reset a clearing pass over all WINDOW slots zeroes both window memories first.
// A stalled result sits in the output register; only the next hand-over waits.
module sliding_window_mean_and_std_core (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire swms_pkg::t_in_item  i_in_data,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output swms_pkg::t_out_item      o_out_data
);

    localparam logic [3:0] ST_CLR   = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_SUM   = 4'd2;
    localparam logic [3:0] ST_MGO   = 4'd3;
    localparam logic [3:0] ST_MWAIT = 4'd4;
    localparam logic [3:0] ST_WR    = 4'd5;
    localparam logic [3:0] ST_SQ    = 4'd6;
    localparam logic [3:0] ST_QGO   = 4'd7;
    localparam logic [3:0] ST_QWAIT = 4'd8;
    localparam logic [3:0] ST_SWAIT = 4'd9;
    localparam logic [3:0] ST_OUT   = 4'd10;

    localparam int DW = swms_pkg::DATA_W;

    logic [3:0] r_state;
    logic [3:0] n_state;

    // Window memories, one row holds all axes of one slot.
    logic [swms_pkg::ROW_W-1:0] mem_smp [0:swms_pkg::WINDOW-1];
    logic [swms_pkg::ROW_W-1:0] mem_dev [0:swms_pkg::WINDOW-1];
    logic [swms_pkg::ROW_W-1:0] r_smp_rd;
    logic [swms_pkg::ROW_W-1:0] r_dev_rd;

    logic [swms_pkg::ADDR_W-1:0]    r_head;
    logic [swms_pkg::ADDR_W-1:0]    r_clr;
    logic [swms_pkg::IDX_W-1:0]     r_idx;
    logic [swms_pkg::AX_W-1:0]      r_ax;
    logic [swms_pkg::WARM_W-1:0]    r_warm;
    logic [swms_pkg::WARM_W-1:0]    n_warm;
    logic                           r_vld;

    logic signed [DW-1:0]           r_in   [0:swms_pkg::NAXES-1];
    logic signed [swms_pkg::SUM_W-1:0] r_sum [0:swms_pkg::NAXES-1];
    logic [DW-1:0]                  r_mean [0:swms_pkg::NAXES-1];
    logic [DW-1:0]                  r_dev  [0:swms_pkg::NAXES-1];
    logic [DW-1:0]                  r_std  [0:swms_pkg::NAXES-1];

    logic                           r_rv;
    logic                           r_pv;
    logic [63:0]                    r_prod;
    logic [swms_pkg::ACC_W-1:0]     r_acc;

    logic                           r_ovld;
    swms_pkg::t_out_item            r_out;

    logic                           rd_en;
    logic                           div_start;
    logic [swms_pkg::ACC_W-1:0]     div_dividend;
    logic                           div_done;
    logic [swms_pkg::ACC_W-1:0]     div_quot;
    logic                           sqrt_start;
    logic                           sqrt_done;
    logic [DW-1:0]                  sqrt_root;

    logic                           sum_neg;
    logic [swms_pkg::SUM_W-1:0]     sum_mag;
    logic [DW:0]                    mean_q;
    logic [DW:0]                    mean_s;
    logic [DW+1:0]                  dev_w;
    logic [DW-1:0]                  dev_sat;
    logic signed [DW-1:0]           dev_sel;
    logic [DW-1:0]                  dev_mag;
    logic                           out_load;
    logic                           last_ax;

    swms_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    swms_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sqrt_start),
        .i_value (div_quot[63:0]),
        .o_done  (sqrt_done),
        .o_root  (sqrt_root)
    );

    // Mean of the current axis: magnitude division, then the sign goes back
    // on, which rounds toward zero. The deviation is saturated to 32 bits.
    always_comb begin
        sum_neg = r_sum[r_ax][swms_pkg::SUM_W-1];
        sum_mag = sum_neg ? swms_pkg::SUM_W'(-r_sum[r_ax]) : swms_pkg::SUM_W'(r_sum[r_ax]);
        mean_q  = div_quot[DW:0];
        mean_s  = sum_neg ? (DW+1)'(-mean_q) : mean_q;
        dev_w   = {{2{r_in[r_ax][DW-1]}}, r_in[r_ax]} - {mean_s[DW], mean_s};
        if (dev_w[DW+1:DW-1] == 3'b000 || dev_w[DW+1:DW-1] == 3'b111) begin
            dev_sat = dev_w[DW-1:0];
        end else if (dev_w[DW+1]) begin
            dev_sat = {1'b1, {(DW-1){1'b0}}};
        end else begin
            dev_sat = {1'b0, {(DW-1){1'b1}}};
        end
        dev_sel = r_dev_rd[DW*r_ax +: DW];
        dev_mag = dev_sel[DW-1] ? DW'(-dev_sel) : DW'(dev_sel);
        n_warm  = (r_warm < swms_pkg::WARM_W'(swms_pkg::WARMUP)) ? r_warm + 1'b1 : r_warm;
        last_ax = r_ax == swms_pkg::AX_W'(swms_pkg::AXES - 1);
        rd_en   = (r_state == ST_SQ) && (r_idx < swms_pkg::IDX_W'(swms_pkg::WINDOW));
        div_start    = (r_state == ST_MGO) || (r_state == ST_QGO);
        div_dividend = (r_state == ST_MGO) ? swms_pkg::ACC_W'(sum_mag) : r_acc;
        sqrt_start   = (r_state == ST_QWAIT) && div_done;
        out_load     = (r_state == ST_OUT) && (!r_ovld || !i_out_stall);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLR: begin
                if (r_clr == swms_pkg::ADDR_W'(swms_pkg::WINDOW - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_SUM;
                end
            end
            ST_SUM:   n_state = ST_MGO;
            ST_MGO:   n_state = ST_MWAIT;
            ST_MWAIT: begin
                if (div_done) begin
                    n_state = last_ax ? ST_WR : ST_MGO;
                end
            end
            ST_WR: begin
                n_state = (n_warm >= swms_pkg::WARM_W'(swms_pkg::WARMUP)) ? ST_SQ : ST_OUT;
            end
            ST_SQ: begin
                if (r_idx == swms_pkg::IDX_W'(swms_pkg::WINDOW) && !r_rv && !r_pv) begin
                    n_state = ST_QGO;
                end
            end
            ST_QGO:   n_state = ST_QWAIT;
            ST_QWAIT: begin
                if (div_done) begin
                    n_state = ST_SWAIT;
                end
            end
            ST_SWAIT: begin
                if (sqrt_done) begin
                    n_state = last_ax ? ST_OUT : ST_SQ;
                end
            end
            ST_OUT: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_CLR;
        endcase
    end

    // Window memories: one write port each, registered reads.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_CLR) begin
            mem_smp[r_clr] <= '0;
            mem_dev[r_clr] <= '0;
        end else if (r_state == ST_WR) begin
            mem_smp[r_head] <= {r_in[2], r_in[1], r_in[0]};
            mem_dev[r_head] <= {r_dev[2], r_dev[1], r_dev[0]};
        end
        r_smp_rd <= mem_smp[r_head];
        if (rd_en) begin
            r_dev_rd <= mem_dev[r_idx[swms_pkg::ADDR_W-1:0]];
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_prod <= 64'(dev_mag) * 64'(dev_mag);
        if (r_state == ST_IDLE && i_in_valid) begin
            r_in[0] <= i_in_data.rate_x;
            r_in[1] <= i_in_data.rate_y;
            r_in[2] <= i_in_data.rate_z;
            for (int a = 0; a < swms_pkg::NAXES; a++) begin
                r_mean[a] <= '0;
                r_std[a]  <= '0;
                r_dev[a]  <= '0;
            end
        end
        if (r_state == ST_MWAIT && div_done) begin
            r_mean[r_ax] <= mean_s[DW-1:0];
            r_dev[r_ax]  <= dev_sat;
        end
        if (r_state == ST_WR || (r_state == ST_SWAIT && sqrt_done)) begin
            r_acc <= '0;
        end else if (r_pv) begin
            r_acc <= r_acc + swms_pkg::ACC_W'(r_prod);
        end
        if (r_state == ST_SWAIT && sqrt_done) begin
            r_std[r_ax] <= sqrt_root;
        end
        if (out_load) begin
            r_out.valid_res <= r_vld;
            r_out.std_x     <= r_std[0];
            r_out.std_y     <= r_std[1];
            r_out.std_z     <= r_std[2];
            r_out.mean_x    <= r_mean[0];
            r_out.mean_y    <= r_mean[1];
            r_out.mean_z    <= r_mean[2];
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLR;
            r_clr   <= '0;
            r_head  <= '0;
            r_idx   <= '0;
            r_ax    <= '0;
            r_warm  <= '0;
            r_vld   <= 1'b0;
            r_rv    <= 1'b0;
            r_pv    <= 1'b0;
            r_ovld  <= 1'b0;
            for (int a = 0; a < swms_pkg::NAXES; a++) begin
                r_sum[a] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_rv    <= rd_en;
            r_pv    <= r_rv;
            if (r_state == ST_CLR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (r_state == ST_SUM) begin
                r_ax <= '0;
                for (int a = 0; a < swms_pkg::NAXES; a++) begin
                    r_sum[a] <= r_sum[a]
                        - {{(swms_pkg::SUM_W-DW){r_smp_rd[DW*a+DW-1]}}, r_smp_rd[DW*a +: DW]}
                        + {{(swms_pkg::SUM_W-DW){r_in[a][DW-1]}}, r_in[a]};
                end
            end
            if (r_state == ST_MWAIT && div_done && !last_ax) begin
                r_ax <= r_ax + 1'b1;
            end
            if (r_state == ST_WR) begin
                r_ax   <= '0;
                r_idx  <= '0;
                r_warm <= n_warm;
                r_vld  <= n_warm >= swms_pkg::WARM_W'(swms_pkg::WARMUP);
                if (r_head == swms_pkg::ADDR_W'(swms_pkg::WINDOW - 1)) begin
                    r_head <= '0;
                end else begin
                    r_head <= r_head + 1'b1;
                end
            end
            if (rd_en) begin
                r_idx <= r_idx + 1'b1;
            end
            if (r_state == ST_SWAIT && sqrt_done && !last_ax) begin
                r_ax  <= r_ax + 1'b1;
                r_idx <= '0;
            end
            if (out_load) begin
                r_ovld <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovld <= 1'b0;
            end
        end
    end

    assign o_in_stall  = r_state != ST_IDLE;
    assign o_out_valid = r_ovld;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire
